// ----- rtl/normal_cdf_and_inverse_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the normal cdf and inverse block
// Shared wrappers for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef NORMAL_CDF_AND_INVERSE_TOP_ASSERT_SVH
`define NORMAL_CDF_AND_INVERSE_TOP_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge out of reset.
`define NCDF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ncdf assertion failed");

// Next-cycle implication checked at every rising clock edge out of reset.
`define NCDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ncdf assertion failed");

`endif

// ----- rtl/ncdf_pkg.sv -----
// ----------------------------------------------------------------------------
// ncdf_pkg
// Types, formats and constants shared by the normal cdf and inverse block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncdf_pkg;

    localparam int ARG_W      = 29;
    localparam int PROB_W     = 31;
    localparam int TOL_W      = 11;
    localparam int ARG_FRAC   = 24;
    localparam int PROB_FRAC  = 30;
    localparam int QP         = 40;   // fraction bits of a, coefficients and y
    localparam int QR         = 62;   // fraction bits of the reciprocal
    localparam int A_W        = ARG_W - 1 + QP - ARG_FRAC;
    localparam int ACC_W      = 48;
    localparam int Q_W        = 63;
    localparam int OP_W       = 64;
    localparam int H_SH       = 63 - PROB_FRAC;
    localparam int POS_W      = ARG_W + 1;

    localparam logic [TOL_W-1:0]        TOL_RESET = TOL_W'(11);
    localparam logic [PROB_W-1:0]       ONE_P     = PROB_W'(1) << PROB_FRAC;
    localparam logic signed [ARG_W-1:0] TEN_X     = ARG_W'(10) << ARG_FRAC;
    localparam logic [ACC_W-1:0]        ONE_Y     = ACC_W'(1) << QP;

    // Rounded coefficient n * 2^QP / 10^10.
    function automatic logic [ACC_W-1:0] f_coef(input logic [63:0] n);
        logic [127:0] t;
        t = ({64'd0, n} << QP) + 128'd5000000000;
        return ACC_W'(t / 128'd10000000000);
    endfunction

    localparam logic [ACC_W-1:0] COEF [6] = '{
        f_coef(64'd498673470), f_coef(64'd211410061), f_coef(64'd32776263),
        f_coef(64'd380036),    f_coef(64'd488906),    f_coef(64'd53830)
    };

    typedef enum logic [2:0] {
        C_IDLE, C_H_GO, C_H_WAIT, C_D_GO, C_D_WAIT, C_S_GO, C_S_WAIT, C_DONE
    } t_cdf_state;

    typedef enum logic [1:0] {
        T_IDLE, T_GO, T_WAIT, T_OUT
    } t_top_state;

    typedef struct packed {
        logic            go;
        logic            qsel;   // 1: shift by QR, 0: shift by QP
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [OP_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic              done;
        logic [PROB_W-1:0] value;
    } t_cdf_rsp;

endpackage

// ----- rtl/normal_cdf_and_inverse_top.sv -----
// ----------------------------------------------------------------------------
// normal_cdf_and_inverse_top
// Cumulative standard normal distribution and its inverse by bisection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries one request: mode, argument
//   (signed, 24 fraction bits) and probability (30 fraction bits).
//   Output channel o_out_valid/i_out_ready returns one result per request.
//   Configuration channel i_cfg_valid/o_cfg_ready writes the tolerance; it
//   is always ready and should only be written while the block is idle.
//   One cdf evaluation runs a start step, six multiplies on the shared
//   multiplier, a reciprocal that yields one quotient bit a cycle, four
//   squarings and an end step. Arguments at or beyond +/-10 skip the
//   multiplies and the reciprocal, and probabilities of zero and of one
//   or more are valid at the output on the cycle after accept.
//   An inverse request runs up to MAX_STEPS cdf evaluations in series.
//   The block holds one request at a time: o_in_ready is low from accept
//   until the result is taken. A stalled result stays in the output
//   registers unchanged. Reset returns to idle and sets the tolerance to 11.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module normal_cdf_and_inverse_top #(
    parameter int MAX_STEPS = 40
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic signed [ncdf_pkg::ARG_W-1:0]  i_argument,
    input  logic [ncdf_pkg::PROB_W-1:0]        i_probability,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ncdf_pkg::PROB_W-1:0]        o_cdf_value,
    output logic signed [ncdf_pkg::ARG_W-1:0]  o_inverse_value,
    output logic                               o_step_limit_hit,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ncdf_pkg::TOL_W-1:0]         i_cfg_data
);
    import ncdf_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(MAX_STEPS);

    t_top_state               r_state, n_state;
    logic                     r_mode, r_flag;
    logic [PROB_W-1:0]        r_p, r_cdf_out;
    logic signed [POS_W-1:0]  r_down, r_up;
    logic signed [ARG_W-1:0]  r_x, r_inv_out;
    logic [STEP_W-1:0]        r_steps;
    logic [TOL_W-1:0]         r_tol;

    t_cdf_rsp                 cdf_rsp;
    logic                     cdf_go, accept, p_edge, hit, cap, dir_up;
    logic [PROB_W-1:0]        c, diff;
    logic signed [POS_W-1:0]  x_ext, n_down, n_up, span, n_mid;

    ncdf_cdf u_cdf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (cdf_go),
        .i_x     (r_x),
        .o_rsp   (cdf_rsp)
    );

    always_comb begin
        accept = i_in_valid && o_in_ready;
        p_edge = (i_probability == '0) || (i_probability >= ONE_P);
        c      = cdf_rsp.value;
        dir_up = c > r_p;
        diff   = dir_up ? c - r_p : r_p - c;
        hit    = diff <= PROB_W'(r_tol);
        cap    = r_steps >= STEP_CAP;
        x_ext  = POS_W'(r_x);
        n_down = dir_up ? r_down : x_ext;
        n_up   = dir_up ? x_ext : r_up;
        span   = n_up - n_down;
        n_mid  = n_down + (span >>> 1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: if (accept) n_state = (i_mode && p_edge) ? T_OUT : T_GO;
            T_GO:   n_state = T_WAIT;
            T_WAIT: if (cdf_rsp.done) n_state = (!r_mode || hit || cap) ? T_OUT : T_GO;
            T_OUT:  if (i_out_ready) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == T_IDLE);
        o_out_valid = (r_state == T_OUT);
        o_cfg_ready = 1'b1;
        cdf_go      = (r_state == T_GO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_tol   <= TOL_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    r_mode    <= i_mode;
                    r_p       <= i_probability;
                    r_cdf_out <= '0;
                    r_flag    <= 1'b0;
                    r_down    <= -POS_W'(TEN_X);
                    r_up      <= POS_W'(TEN_X);
                    r_steps   <= STEP_W'(1);
                    if (!i_mode) begin
                        r_x       <= i_argument;
                        r_inv_out <= '0;
                    end else begin
                        r_x       <= '0;
                        r_inv_out <= (i_probability == '0) ? -TEN_X : TEN_X;
                    end
                end
            end
            T_WAIT: begin
                if (cdf_rsp.done) begin
                    if (!r_mode) begin
                        r_cdf_out <= c;
                    end else if (hit || cap) begin
                        r_inv_out <= r_x;
                        r_flag    <= !hit;
                    end else begin
                        r_down  <= n_down;
                        r_up    <= n_up;
                        r_x     <= ARG_W'(n_mid);
                        r_steps <= r_steps + STEP_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_cdf_value      = r_cdf_out;
    assign o_inverse_value  = r_inv_out;
    assign o_step_limit_hit = r_flag;

endmodule

// ----- rtl/ncdf_mul.sv -----
// ----------------------------------------------------------------------------
// ncdf_mul
// Shared 64x64 multiplier built from one 32x32 unit that forms four partial
// products in turn, followed by a round-to-nearest right shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncdf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ncdf_pkg::t_mul_req  i_req,
    output ncdf_pkg::t_mul_rsp  o_rsp
);
    import ncdf_pkg::*;

    logic [OP_W-1:0]   r_a, r_b, r_prod;
    logic [2*OP_W-1:0] r_acc;
    logic [1:0]        r_cnt;
    logic              r_busy, r_fin, r_done, r_qsel;

    logic [31:0]       half_a, half_b;
    logic [63:0]       pp;
    logic [2*OP_W-1:0] pp_sh, rsum;

    always_comb begin
        half_a = r_cnt[0] ? r_a[63:32] : r_a[31:0];
        half_b = r_cnt[1] ? r_b[63:32] : r_b[31:0];
        pp     = half_a * half_b;
        case (r_cnt)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        rsum = r_acc + (r_qsel ? (128'd1 << (QR - 1)) : (128'd1 << (QP - 1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_qsel <= i_req.qsel;
                r_acc  <= '0;
                r_cnt  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + pp_sh;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_prod <= r_qsel ? rsum[QR+OP_W-1:QR] : rsum[QP+OP_W-1:QP];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

// ----- rtl/ncdf_div.sv -----
// ----------------------------------------------------------------------------
// ncdf_div
// Restoring divider, one quotient bit a cycle, for 2^(QP+QR) / y.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncdf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [ncdf_pkg::ACC_W-1:0] i_den,
    output logic                      o_done,
    output logic [ncdf_pkg::Q_W-1:0]  o_quo
);
    import ncdf_pkg::*;

    localparam int IDX_W = $clog2(QP + QR + 1);
    localparam logic [IDX_W-1:0] DIV_TOP = IDX_W'(QP + QR);

    logic [ACC_W-1:0] r_rem, r_den;
    logic [Q_W-1:0]   r_quo;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy, r_done;

    logic [ACC_W-1:0] sh_rem, n_rem;
    logic             n_bit;

    // The dividend is a single one bit at the top position.
    always_comb begin
        sh_rem = {r_rem[ACC_W-2:0], r_idx == DIV_TOP};
        n_bit  = sh_rem >= r_den;
        n_rem  = n_bit ? sh_rem - r_den : sh_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_idx  <= DIV_TOP;
                r_rem  <= '0;
                r_quo  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[Q_W-2:0], n_bit};
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/ncdf_cdf.sv -----
// ----------------------------------------------------------------------------
// ncdf_cdf
// Sequencer for one cdf evaluation: Horner polynomial, reciprocal and four
// squarings on the shared multiplier and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncdf_cdf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic signed [ncdf_pkg::ARG_W-1:0] i_x,
    output ncdf_pkg::t_cdf_rsp                o_rsp
);
    import ncdf_pkg::*;

    t_cdf_state        r_state, n_state;
    logic              r_neg;
    logic [A_W-1:0]    r_a;
    logic [ACC_W-1:0]  r_acc;
    logic [Q_W-1:0]    r_r;
    logic [2:0]        r_k;
    logic [PROB_W-1:0] r_value;

    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;
    logic              div_go, div_done;
    logic [Q_W-1:0]    div_quo;

    logic              big_pos, big_neg;
    logic [ARG_W-1:0]  x_abs;
    logic [OP_W-1:0]   hsum;
    logic [PROB_W-1:0] h;

    ncdf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    ncdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_den   (r_acc),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        big_pos = i_x >= TEN_X;
        big_neg = i_x <= -TEN_X;
        x_abs   = i_x[ARG_W-1] ? ARG_W'(-i_x) : ARG_W'(i_x);
        hsum    = mul_rsp.prod + (OP_W'(1) << (H_SH - 1));
        h       = hsum[H_SH+PROB_W-1:H_SH];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:   if (i_go) n_state = (big_pos || big_neg) ? C_DONE : C_H_GO;
            C_H_GO:   n_state = C_H_WAIT;
            C_H_WAIT: if (mul_rsp.done) n_state = (r_k == 3'd0) ? C_D_GO : C_H_GO;
            C_D_GO:   n_state = C_D_WAIT;
            C_D_WAIT: if (div_done) n_state = C_S_GO;
            C_S_GO:   n_state = C_S_WAIT;
            C_S_WAIT: if (mul_rsp.done) n_state = (r_k == 3'd1) ? C_DONE : C_S_GO;
            C_DONE:   n_state = C_IDLE;
            default:  n_state = C_IDLE;
        endcase
    end

    always_comb begin
        mul_req.go   = (r_state == C_H_GO) || (r_state == C_S_GO);
        mul_req.qsel = (r_state == C_S_GO);
        mul_req.a    = mul_req.qsel ? OP_W'(r_r) : OP_W'(r_a);
        mul_req.b    = mul_req.qsel ? OP_W'(r_r) : OP_W'(r_acc);
        div_go       = (r_state == C_D_GO);
        o_rsp.done   = (r_state == C_DONE);
        o_rsp.value  = r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_go) begin
                    r_neg   <= i_x[ARG_W-1];
                    r_value <= big_pos ? ONE_P : '0;
                    r_a     <= {x_abs[ARG_W-2:0], {(QP - ARG_FRAC){1'b0}}};
                    r_acc   <= COEF[5];
                    r_k     <= 3'd5;
                end
            end
            C_H_WAIT: begin
                if (mul_rsp.done) begin
                    if (r_k == 3'd0) begin
                        r_acc <= ONE_Y + ACC_W'(mul_rsp.prod);
                    end else begin
                        r_acc <= COEF[r_k - 3'd1] + ACC_W'(mul_rsp.prod);
                        r_k   <= r_k - 3'd1;
                    end
                end
            end
            C_D_WAIT: begin
                if (div_done) begin
                    r_r <= div_quo;
                    r_k <= 3'd4;
                end
            end
            C_S_WAIT: begin
                if (mul_rsp.done) begin
                    r_r <= Q_W'(mul_rsp.prod);
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd1) begin
                        r_value <= r_neg ? h : ONE_P - h;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/ncdf_checker.sv -----
// ----------------------------------------------------------------------------
// ncdf_checker
// Port-level checks on the normal cdf and inverse block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncdf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_mode,
    input logic signed [ncdf_pkg::ARG_W-1:0]  i_argument,
    input logic [ncdf_pkg::PROB_W-1:0]        i_probability,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [ncdf_pkg::PROB_W-1:0]        o_cdf_value,
    input logic signed [ncdf_pkg::ARG_W-1:0]  o_inverse_value,
    input logic                               o_step_limit_hit,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [ncdf_pkg::TOL_W-1:0]         i_cfg_data
);
    import ncdf_pkg::*;
    `include "normal_cdf_and_inverse_top_assert.svh"

    // A pending result blocks new requests.
    `NCDF_ASSERT(a_one_in_flight, i_clk, i_rst_n, o_out_valid |-> !o_in_ready)

    // A probability never exceeds one.
    `NCDF_ASSERT(a_cdf_range, i_clk, i_rst_n, o_out_valid |-> o_cdf_value <= ONE_P)

    // The step cap only arises in inverse mode, where the cdf field is zero.
    `NCDF_ASSERT(a_flag_mode, i_clk, i_rst_n, o_out_valid && o_step_limit_hit |-> o_cdf_value == '0)

    // A stalled result holds.
    `NCDF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_cdf_value) && $stable(o_inverse_value) && $stable(o_step_limit_hit))

endmodule

bind normal_cdf_and_inverse_top ncdf_checker u_ncdf_checker (.*);

// ----- sim/normal_cdf_and_inverse_top_test.sv -----
// ----------------------------------------------------------------------------
// normal_cdf_and_inverse_top_test
// Self-checking bench for the normal cdf and inverse block. Requests in both
// modes go through a bit-accurate predictor, and each result is compared with
// the oldest prediction; both channels stall at random, but not in the last run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module normal_cdf_and_inverse_top_test;
    import ncdf_pkg::*;

    localparam int  LIMIT_CYCLES = 20_000_000;
    localparam longint TEN_FIX   = longint'(10) << ARG_FRAC;
    localparam longint ONE_FIX   = longint'(1) << PROB_FRAC;
    localparam int  STEP_CAP     = 40;
    localparam bit  MODE_CDF     = 1'b0;
    localparam bit  MODE_INV     = 1'b1;

    typedef struct {
        logic [PROB_W-1:0]        cdf;
        logic signed [ARG_W-1:0]  inv;
        logic                     hit;
    } t_expected;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_mode;
    logic signed [ARG_W-1:0]    i_argument;
    logic [PROB_W-1:0]          i_probability;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [PROB_W-1:0]          o_cdf_value;
    logic signed [ARG_W-1:0]    o_inverse_value;
    logic                       o_step_limit_hit;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [TOL_W-1:0]           i_cfg_data;

    t_expected      pending_results[$];
    logic [TOL_W-1:0] tol_shadow;
    bit             stall_on;
    int             errors = 0;
    int             n_cdf;
    int             n_inv;
    int             n_capped = 0;
    int             n_cfg;
    longint         cycles = 0;

    normal_cdf_and_inverse_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_argument       (i_argument),
        .i_probability    (i_probability),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cdf_value      (o_cdf_value),
        .o_inverse_value  (o_inverse_value),
        .o_step_limit_hit (o_step_limit_hit),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // (a*b) / 2^s rounded to nearest, saturated to 64 bits.
    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = (p + (128'd1 << (s - 1))) >> s;
        if (p[127:64] != 64'd0)
            return '1;
        return p[63:0];
    endfunction

    function automatic logic [63:0] poly_coef(input int k);
        logic [127:0] n;
        case (k)
            0: n = 128'd498673470;
            1: n = 128'd211410061;
            2: n = 128'd32776263;
            3: n = 128'd380036;
            4: n = 128'd488906;
            default: n = 128'd53830;
        endcase
        n = ((n << QP) + 128'd5000000000) / 128'd10000000000;
        return n[63:0];
    endfunction

    function automatic logic [63:0] normal_cdf(input longint x);
        logic [63:0]  mag;
        logic [63:0]  a;
        logic [63:0]  acc;
        logic [63:0]  y;
        logic [63:0]  h;
        logic [127:0] r;
        if (x >= TEN_FIX)
            return ONE_FIX;
        if (x <= -TEN_FIX)
            return 64'd0;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        a = mag << (QP - ARG_FRAC);
        acc = poly_coef(5);
        for (int k = 4; k >= 0; k--)
            acc = poly_coef(k) + mul_round(a, acc, QP);
        y = (64'd1 << QP) + mul_round(a, acc, QP);
        r = (128'd1 << (QP + QR)) / {64'd0, y};
        for (int k = 0; k < 4; k++)
            r[63:0] = mul_round(r[63:0], r[63:0], QR);
        h = (r[63:0] + (64'd1 << (H_SH - 1))) >> H_SH;
        return (x >= 0) ? 64'(ONE_FIX) - h : h;
    endfunction

    function automatic t_expected predict_result(input logic mode,
                                                 input logic signed [ARG_W-1:0] arg,
                                                 input logic [PROB_W-1:0] prob);
        t_expected e;
        longint    lo;
        longint    hi;
        longint    mid;
        logic [63:0] c;
        logic [63:0] p;
        logic [63:0] diff;
        int        steps;
        e.cdf = '0;
        e.inv = '0;
        e.hit = 1'b0;
        if (mode == MODE_CDF) begin
            e.cdf = PROB_W'(normal_cdf(longint'(arg)));
            return e;
        end
        p = {33'd0, prob};
        if (p == 64'd0) begin
            mid = -TEN_FIX;
        end else if (p >= 64'(ONE_FIX)) begin
            mid = TEN_FIX;
        end else begin
            lo = -TEN_FIX;
            hi = TEN_FIX;
            mid = lo + ((hi - lo) >>> 1);
            c = normal_cdf(mid);
            steps = 1;
            forever begin
                diff = (c > p) ? c - p : p - c;
                if (diff <= {53'd0, tol_shadow})
                    break;
                if (steps >= STEP_CAP) begin
                    e.hit = 1'b1;
                    break;
                end
                if (c > p)
                    hi = mid;
                else
                    lo = mid;
                mid = lo + ((hi - lo) >>> 1);
                c = normal_cdf(mid);
                steps++;
            end
        end
        e.inv = ARG_W'(mid);
        return e;
    endfunction

    // Leaves valid high on return so that back-to-back requests need no toggle.
    task automatic send_request(input logic mode, input logic signed [ARG_W-1:0] arg,
                                input logic [PROB_W-1:0] prob);
        int gap;
        gap = (stall_on && ($urandom_range(0, 3) == 0)) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_argument    <= arg;
        i_probability <= prob;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_results.push_back(predict_result(mode, arg, prob));
        if (mode == MODE_CDF)
            n_cdf++;
        else
            n_inv++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        tol_shadow = value;
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [ARG_W-1:0] random_argument();
        if ($urandom_range(0, 9) == 0)
            return ARG_W'($urandom);
        return ARG_W'(int'($urandom_range(0, 335544320)) - 167772160);
    endfunction

    function automatic logic [PROB_W-1:0] random_probability();
        if ($urandom_range(0, 9) == 0)
            return PROB_W'($urandom);
        return PROB_W'($urandom_range(0, 1073741824));
    endfunction

    task automatic test_cdf_edges();
        send_request(MODE_CDF, '0, '0);
        send_request(MODE_CDF, ARG_W'(TEN_FIX), '1);
        send_request(MODE_CDF, ARG_W'(-TEN_FIX), '0);
        send_request(MODE_CDF, ARG_W'(TEN_FIX - 1), '0);
        send_request(MODE_CDF, ARG_W'(-TEN_FIX + 1), '0);
        send_request(MODE_CDF, {1'b0, {(ARG_W-1){1'b1}}}, '0);
        send_request(MODE_CDF, {1'b1, {(ARG_W-1){1'b0}}}, '1);
        send_request(MODE_CDF, ARG_W'(1), '0);
        send_request(MODE_CDF, ARG_W'(-1), '0);
        send_request(MODE_CDF, ARG_W'(longint'(1) << ARG_FRAC), '0);
        send_request(MODE_CDF, ARG_W'(-(longint'(6) << ARG_FRAC)), '0);
    endtask

    task automatic test_inverse_edges();
        send_request(MODE_INV, '0, '0);
        send_request(MODE_INV, '1, PROB_W'(ONE_FIX));
        send_request(MODE_INV, '0, '1);
        send_request(MODE_INV, '0, PROB_W'(ONE_FIX + 5));
        send_request(MODE_INV, '0, PROB_W'(ONE_FIX / 2));
        send_request(MODE_INV, '0, PROB_W'(1));
        send_request(MODE_INV, '0, PROB_W'(ONE_FIX - 1));
        send_request(MODE_INV, '0, PROB_W'(ONE_FIX / 10));
    endtask

    task automatic test_tolerance_extremes();
        write_tolerance(TOL_W'(0));
        send_request(MODE_INV, '0, PROB_W'(123456789));
        send_request(MODE_INV, '0, PROB_W'(987654321));
        write_tolerance('1);
        send_request(MODE_INV, '0, PROB_W'(300000000));
        send_request(MODE_CDF, ARG_W'(12345678), '0);
        write_tolerance(TOL_W'(1024));
        send_request(MODE_INV, '0, PROB_W'(700000000));
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 59)
                write_tolerance(TOL_W'($urandom_range(0, 2047)));
            if ($urandom_range(0, 9) < 6)
                send_request(MODE_CDF, random_argument(), PROB_W'($urandom));
            else
                send_request(MODE_INV, ARG_W'($urandom), random_probability());
        end
    endtask

    always @(posedge i_clk) begin
        t_expected e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: cdf %0d inv %0d hit %0b",
                         $time, o_cdf_value, o_inverse_value, o_step_limit_hit);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (e.hit)
                    n_capped++;
                if (o_cdf_value !== e.cdf) begin
                    $display("%0t: cdf_value expected %0d actual %0d",
                             $time, e.cdf, o_cdf_value);
                    errors++;
                end
                if (o_inverse_value !== e.inv) begin
                    $display("%0t: inverse_value expected %0d actual %0d",
                             $time, e.inv, o_inverse_value);
                    errors++;
                end
                if (o_step_limit_hit !== e.hit) begin
                    $display("%0t: step_limit_hit expected %0b actual %0b",
                             $time, e.hit, o_step_limit_hit);
                    errors++;
                end
            end
        end
    end

    // Result side backpressure in random bursts.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (stall_on && ($urandom_range(0, 1) == 0)) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("normal_cdf_and_inverse_top: mismatch");
            $finish;
        end
    end

    initial begin
        n_cdf         = 0;
        n_inv         = 0;
        n_cfg         = 0;
        stall_on      = 1'b1;
        tol_shadow    = TOL_RESET;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = 1'b0;
        i_argument    = '0;
        i_probability = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cdf_edges();
        test_inverse_edges();
        test_tolerance_extremes();
        write_tolerance(TOL_RESET);
        test_random_mix(320);
        drain_results();
        stall_on = 1'b0;
        test_random_mix(60);
        drain_results();

        $display("Covered %0d cdf and %0d inverse requests, %0d at the step cap.",
                 n_cdf, n_inv, n_capped);
        $display("Tolerance was written %0d times, with stalls on both channels.", n_cfg);
        if (errors == 0)
            $display("normal_cdf_and_inverse_top: match");
        else
            $display("normal_cdf_and_inverse_top: mismatch");
        $finish;
    end

endmodule
